### hw/rtl/rgb_to_hsv_pixel_assert.svh
// ============================================================================
// RGB to HSV assertion macros
// Shared concurrent assertion forms for the RGB to HSV pixel converter.
// ============================================================================
`ifndef RGB_TO_HSV_PIXEL_ASSERT_SVH
`define RGB_TO_HSV_PIXEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBHSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbhsv: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbhsv: next-cycle check failed");

`endif

### hw/rtl/rgbhsv_pkg.sv
// ============================================================================
// RGB to HSV package
// Types and fixed constants shared by the RGB to HSV converter modules.
// ============================================================================
package rgbhsv_pkg;

    // Width of the gray threshold register and its value after reset.
    localparam int unsigned CFG_BITS      = 16;
    localparam logic [15:0] CFG_THR_RESET = 16'd1;

    // Hue arithmetic in units of 1/64 degree.
    localparam int unsigned HUE_BITS      = 15;
    localparam int unsigned HUE_Q_BITS    = 12;   // 3840 fits in 12 bits
    localparam int unsigned HUE_SUB_SHIFT = 8;    // 3840 = 2^12 - 2^8
    localparam logic [14:0] HUE_SECTOR    = 15'd7680;
    localparam logic [14:0] HUE_SECTOR2   = 15'd15360;
    localparam logic [14:0] HUE_FULL_TURN = 15'd23040;

    // Dominant channel, which selects the hue sector.
    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic    valid;
        logic    gray;
        t_sector sector;
        logic    neg;
    } t_ctl;

endpackage

### hw/rtl/rgbhsv_front.sv
// ============================================================================
// RGB to HSV front end
// Two register stages: max/min and sector pick, then delta, gray test and
// the dividends for the saturation and hue divisions.
// ============================================================================
module rgbhsv_front #(
    parameter int unsigned COLOR_BITS = 16,
    parameter int unsigned STEPS      = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [COLOR_BITS-1:0]               i_red,
    input  logic [COLOR_BITS-1:0]               i_green,
    input  logic [COLOR_BITS-1:0]               i_blue,
    input  logic [rgbhsv_pkg::CFG_BITS-1:0]     i_gray_thr,
    output rgbhsv_pkg::t_ctl                    o_ctl,
    output logic [COLOR_BITS-1:0]               o_max,
    output logic [COLOR_BITS-1:0]               o_delta,
    output logic [COLOR_BITS-1:0]               o_s_rem,
    output logic [STEPS-1:0]                    o_s_q,
    output logic [COLOR_BITS-1:0]               o_h_rem,
    output logic [STEPS-1:0]                    o_h_q
);

    localparam int unsigned DW = STEPS + COLOR_BITS;
    localparam int unsigned TW = (COLOR_BITS > rgbhsv_pkg::CFG_BITS) ?
                                 COLOR_BITS : rgbhsv_pkg::CFG_BITS;

    // Stage A: largest and smallest channel, sector and signed difference.
    logic [COLOR_BITS-1:0] w_max_rg, w_max, w_min_rg, w_min;
    logic [COLOR_BITS:0]   w_diff;
    logic [COLOR_BITS:0]   w_diff_neg;
    rgbhsv_pkg::t_sector   w_sector;

    assign w_max_rg   = (i_red > i_green) ? i_red : i_green;
    assign w_max      = (w_max_rg > i_blue) ? w_max_rg : i_blue;
    assign w_min_rg   = (i_red < i_green) ? i_red : i_green;
    assign w_min      = (w_min_rg < i_blue) ? w_min_rg : i_blue;

    // Ties go to red first, then to green.
    always_comb begin
        if (i_red >= w_max) begin
            w_sector = rgbhsv_pkg::SECT_RED;
            w_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= w_max) begin
            w_sector = rgbhsv_pkg::SECT_GREEN;
            w_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            w_sector = rgbhsv_pkg::SECT_BLUE;
            w_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
    end

    assign w_diff_neg = -w_diff;

    rgbhsv_pkg::t_ctl      r_a_ctl, n_a_ctl;
    logic [COLOR_BITS-1:0] r_a_max, r_a_min, r_a_abs;

    always_comb begin
        n_a_ctl        = '0;
        n_a_ctl.valid  = i_valid;
        n_a_ctl.sector = w_sector;
        n_a_ctl.neg    = w_diff[COLOR_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_max <= w_max;
            r_a_min <= w_min;
            r_a_abs <= w_diff[COLOR_BITS] ? w_diff_neg[COLOR_BITS-1:0]
                                          : w_diff[COLOR_BITS-1:0];
        end
    end

    // Stage B: delta, gray decision and the two dividends split into
    // starting remainder and the bits still to be shifted in.
    logic [COLOR_BITS-1:0] w_delta;
    logic [TW-1:0]         w_delta_ext, w_thr_ext;
    logic                  w_gray;
    logic [DW-1:0]         w_s_div, w_h_div;

    assign w_delta     = r_a_max - r_a_min;
    assign w_delta_ext = TW'(w_delta);
    assign w_thr_ext   = TW'(i_gray_thr);
    assign w_gray      = (w_delta == '0) || (w_delta_ext < w_thr_ext);

    // FULL * delta and 3840 * |diff| built from shifts.
    assign w_s_div = (DW'(w_delta) << COLOR_BITS) - DW'(w_delta);
    assign w_h_div = (DW'(r_a_abs) << rgbhsv_pkg::HUE_Q_BITS)
                   - (DW'(r_a_abs) << rgbhsv_pkg::HUE_SUB_SHIFT);

    rgbhsv_pkg::t_ctl r_b_ctl, n_b_ctl;

    always_comb begin
        n_b_ctl      = r_a_ctl;
        n_b_ctl.gray = w_gray;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= n_b_ctl;
        end
    end

    logic [COLOR_BITS-1:0] r_b_max, r_b_delta, r_b_s_rem, r_b_h_rem;
    logic [STEPS-1:0]      r_b_s_q, r_b_h_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_max   <= r_a_max;
            r_b_delta <= w_delta;
            r_b_s_rem <= w_s_div[DW-1:STEPS];
            r_b_s_q   <= w_s_div[STEPS-1:0];
            r_b_h_rem <= w_h_div[DW-1:STEPS];
            r_b_h_q   <= w_h_div[STEPS-1:0];
        end
    end

    assign o_ctl   = r_b_ctl;
    assign o_max   = r_b_max;
    assign o_delta = r_b_delta;
    assign o_s_rem = r_b_s_rem;
    assign o_s_q   = r_b_s_q;
    assign o_h_rem = r_b_h_rem;
    assign o_h_q   = r_b_h_q;

endmodule

### hw/rtl/rgbhsv_cell.sv
// ============================================================================
// RGB to HSV divider cell
// One restoring division step for the saturation lane and one for the hue
// lane, registered, with the item's control and divisors passed along.
// ============================================================================
module rgbhsv_cell #(
    parameter int unsigned COLOR_BITS = 16,
    parameter int unsigned STEPS      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  rgbhsv_pkg::t_ctl      i_ctl,
    input  logic [COLOR_BITS-1:0] i_max,
    input  logic [COLOR_BITS-1:0] i_delta,
    input  logic [COLOR_BITS-1:0] i_s_rem,
    input  logic [STEPS-1:0]      i_s_q,
    input  logic [COLOR_BITS-1:0] i_h_rem,
    input  logic [STEPS-1:0]      i_h_q,
    output rgbhsv_pkg::t_ctl      o_ctl,
    output logic [COLOR_BITS-1:0] o_max,
    output logic [COLOR_BITS-1:0] o_delta,
    output logic [COLOR_BITS-1:0] o_s_rem,
    output logic [STEPS-1:0]      o_s_q,
    output logic [COLOR_BITS-1:0] o_h_rem,
    output logic [STEPS-1:0]      o_h_q
);

    // Saturation lane: divide by the largest channel.
    logic [COLOR_BITS:0]   w_s_trial, w_s_sub;
    logic                  w_s_ge;
    logic [COLOR_BITS-1:0] w_s_rem;

    assign w_s_trial = {i_s_rem, i_s_q[STEPS-1]};
    assign w_s_ge    = (w_s_trial >= {1'b0, i_max});
    assign w_s_sub   = w_s_trial - {1'b0, i_max};
    assign w_s_rem   = w_s_ge ? w_s_sub[COLOR_BITS-1:0] : w_s_trial[COLOR_BITS-1:0];

    // Hue lane: divide by delta.
    logic [COLOR_BITS:0]   w_h_trial, w_h_sub;
    logic                  w_h_ge;
    logic [COLOR_BITS-1:0] w_h_rem;

    assign w_h_trial = {i_h_rem, i_h_q[STEPS-1]};
    assign w_h_ge    = (w_h_trial >= {1'b0, i_delta});
    assign w_h_sub   = w_h_trial - {1'b0, i_delta};
    assign w_h_rem   = w_h_ge ? w_h_sub[COLOR_BITS-1:0] : w_h_trial[COLOR_BITS-1:0];

    // Control register.
    rgbhsv_pkg::t_ctl r_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Payload registers; quotient bits enter at the bottom.
    logic [COLOR_BITS-1:0] r_max, r_delta, r_s_rem, r_h_rem;
    logic [STEPS-1:0]      r_s_q, r_h_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max   <= i_max;
            r_delta <= i_delta;
            r_s_rem <= w_s_rem;
            r_s_q   <= {i_s_q[STEPS-2:0], w_s_ge};
            r_h_rem <= w_h_rem;
            r_h_q   <= {i_h_q[STEPS-2:0], w_h_ge};
        end
    end

    assign o_ctl   = r_ctl;
    assign o_max   = r_max;
    assign o_delta = r_delta;
    assign o_s_rem = r_s_rem;
    assign o_s_q   = r_s_q;
    assign o_h_rem = r_h_rem;
    assign o_h_q   = r_h_q;

endmodule

### hw/rtl/rgb_to_hsv_pixel.sv
// ============================================================================
// RGB to HSV pixel converter
// Converts one RGB pixel per cycle, unless the output stalls, to hue,
// saturation and value through a front end and a chain of divider cells.
// ============================================================================
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+------------------------------------
//  pixel   | i_pix_valid / o_pix_stall  | i_red_level, i_green_level,
//          |                            | i_blue_level
//  hsv     | o_hsv_valid / i_hsv_stall  | o_hue_x64, o_saturation,
//          |                            | o_brightness, o_is_gray
//  config  | i_cfg_we                   | i_cfg_wdata (gray threshold)
//
// One pixel is accepted per cycle while the output is not stalled. The
// chain holds two front stages, one divider cell per quotient bit
// (STEPS = max(COLOR_BITS, 12) cells) and one output register.
// A stall on the output freezes the whole chain; an input skid register
// absorbs the one pixel that arrives in that cycle, so o_pix_stall is a
// register output. Reset is synchronous and resets only control state and the gray threshold.
// ============================================================================
`include "rgb_to_hsv_pixel_assert.svh"

module rgb_to_hsv_pixel #(
    parameter int unsigned COLOR_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_pix_valid,
    output logic                                    o_pix_stall,
    input  logic [COLOR_BITS-1:0]                   i_red_level,
    input  logic [COLOR_BITS-1:0]                   i_green_level,
    input  logic [COLOR_BITS-1:0]                   i_blue_level,
    output logic                                    o_hsv_valid,
    input  logic                                    i_hsv_stall,
    output logic [rgbhsv_pkg::HUE_BITS-1:0]         o_hue_x64,
    output logic [COLOR_BITS-1:0]                   o_saturation,
    output logic [COLOR_BITS-1:0]                   o_brightness,
    output logic                                    o_is_gray,
    input  logic                                    i_cfg_we,
    input  logic [rgbhsv_pkg::CFG_BITS-1:0]         i_cfg_wdata
);

    localparam int unsigned STEPS = (COLOR_BITS > rgbhsv_pkg::HUE_Q_BITS) ?
                                    COLOR_BITS : rgbhsv_pkg::HUE_Q_BITS;

    // Gray threshold register.
    logic [rgbhsv_pkg::CFG_BITS-1:0] r_gray_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_thr <= rgbhsv_pkg::CFG_THR_RESET;
        end else if (i_cfg_we) begin
            r_gray_thr <= i_cfg_wdata;
        end
    end

    // The chain advances whenever the output register is free or drained.
    logic w_en;
    logic r_out_valid;

    assign w_en = !r_out_valid || !i_hsv_stall;

    // Input skid register.
    logic                  r_skid_full;
    logic [COLOR_BITS-1:0] r_skid_red, r_skid_green, r_skid_blue;
    logic                  w_in_acc;

    assign w_in_acc    = i_pix_valid && !r_skid_full;
    assign o_pix_stall = r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (w_en) begin
            r_skid_full <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_en) begin
            r_skid_red   <= i_red_level;
            r_skid_green <= i_green_level;
            r_skid_blue  <= i_blue_level;
        end
    end

    // The chain takes the skid item first, otherwise the port item.
    logic                  w_src_valid;
    logic [COLOR_BITS-1:0] w_src_red, w_src_green, w_src_blue;

    assign w_src_valid = r_skid_full || i_pix_valid;
    assign w_src_red   = r_skid_full ? r_skid_red   : i_red_level;
    assign w_src_green = r_skid_full ? r_skid_green : i_green_level;
    assign w_src_blue  = r_skid_full ? r_skid_blue  : i_blue_level;

    // Links between the front end and the cells.
    rgbhsv_pkg::t_ctl      w_ctl   [0:STEPS];
    logic [COLOR_BITS-1:0] w_max   [0:STEPS];
    logic [COLOR_BITS-1:0] w_delta [0:STEPS];
    logic [COLOR_BITS-1:0] w_s_rem [0:STEPS];
    logic [STEPS-1:0]      w_s_q   [0:STEPS];
    logic [COLOR_BITS-1:0] w_h_rem [0:STEPS];
    logic [STEPS-1:0]      w_h_q   [0:STEPS];

    rgbhsv_front #(
        .COLOR_BITS (COLOR_BITS),
        .STEPS      (STEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_src_valid),
        .i_red      (w_src_red),
        .i_green    (w_src_green),
        .i_blue     (w_src_blue),
        .i_gray_thr (r_gray_thr),
        .o_ctl      (w_ctl[0]),
        .o_max      (w_max[0]),
        .o_delta    (w_delta[0]),
        .o_s_rem    (w_s_rem[0]),
        .o_s_q      (w_s_q[0]),
        .o_h_rem    (w_h_rem[0]),
        .o_h_q      (w_h_q[0])
    );

    // One divider cell per quotient bit.
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        rgbhsv_cell #(
            .COLOR_BITS (COLOR_BITS),
            .STEPS      (STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_max   (w_max[g]),
            .i_delta (w_delta[g]),
            .i_s_rem (w_s_rem[g]),
            .i_s_q   (w_s_q[g]),
            .i_h_rem (w_h_rem[g]),
            .i_h_q   (w_h_q[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_max   (w_max[g+1]),
            .o_delta (w_delta[g+1]),
            .o_s_rem (w_s_rem[g+1]),
            .o_s_q   (w_s_q[g+1]),
            .o_h_rem (w_h_rem[g+1]),
            .o_h_q   (w_h_q[g+1])
        );
    end

    // Hue assembly: sector base plus or minus the quotient, wrapped once.
    rgbhsv_pkg::t_ctl                w_last;
    logic [rgbhsv_pkg::HUE_BITS-1:0] w_base, w_q, w_hue;

    assign w_last = w_ctl[STEPS];
    assign w_q    = rgbhsv_pkg::HUE_BITS'(w_h_q[STEPS][rgbhsv_pkg::HUE_Q_BITS-1:0]);

    always_comb begin
        unique case (w_last.sector)
            rgbhsv_pkg::SECT_RED:   w_base = '0;
            rgbhsv_pkg::SECT_GREEN: w_base = rgbhsv_pkg::HUE_SECTOR;
            default:                w_base = rgbhsv_pkg::HUE_SECTOR2;
        endcase
    end

    always_comb begin
        if (w_last.gray) begin
            w_hue = '0;
        end else if (!w_last.neg) begin
            w_hue = w_base + w_q;
        end else if (w_base == '0 && w_q != '0) begin
            w_hue = rgbhsv_pkg::HUE_FULL_TURN - w_q;
        end else begin
            w_hue = w_base - w_q;
        end
    end

    // Output register.
    logic [rgbhsv_pkg::HUE_BITS-1:0] r_hue;
    logic [COLOR_BITS-1:0]           r_sat, r_bright;
    logic                            r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue    <= w_hue;
            r_sat    <= w_last.gray ? '0 : w_s_q[STEPS][COLOR_BITS-1:0];
            r_bright <= w_max[STEPS];
            r_gray   <= w_last.gray;
        end
    end

    assign o_hsv_valid  = r_out_valid;
    assign o_hue_x64    = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;
    assign o_is_gray    = r_gray;

    // A gray pixel carries neither hue nor saturation.
    `RGBHSV_ASSERT_SAME(a_gray_zero, i_clk, i_rst_n, r_out_valid && r_gray, r_hue == '0 && r_sat == '0)

    // A colored pixel has a hue inside one turn.
    `RGBHSV_ASSERT_SAME(a_hue_range, i_clk, i_rst_n, r_out_valid && !r_gray, r_hue < rgbhsv_pkg::HUE_FULL_TURN)

    // A colored pixel has nonzero saturation and brightness.
    `RGBHSV_ASSERT_SAME(a_sat_nonzero, i_clk, i_rst_n, r_out_valid && !r_gray, r_sat != '0 && r_bright != '0)

    // A held skid item stays held while the chain is frozen.
    `RGBHSV_ASSERT_NEXT(a_skid_hold, i_clk, i_rst_n, r_skid_full && !w_en, r_skid_full)

endmodule

### tb/sv/rgb_to_hsv_pixel_check.sv
`timescale 1ns / 100ps
// ============================================================================
// RGB to HSV pixel result check
// Watches the pixel, hsv and threshold ports of the converter, predicts the
// hue, saturation, value and gray flag of each accepted pixel, and compares
// each accepted result against the oldest outstanding prediction.
// ============================================================================
module rgb_to_hsv_pixel_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    input  logic        i_pix_stall,
    input  logic [15:0] i_red_level,
    input  logic [15:0] i_green_level,
    input  logic [15:0] i_blue_level,
    input  logic        i_hsv_valid,
    input  logic        i_hsv_stall,
    input  logic [14:0] i_hue_x64,
    input  logic [15:0] i_saturation,
    input  logic [15:0] i_brightness,
    input  logic        i_is_gray,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam longint HALF_SECTOR = 3840;
    localparam longint FULL_SCALE  = 65535;

    typedef struct packed {
        logic [14:0] hue_x64;
        logic [15:0] saturation;
        logic [15:0] brightness;
        logic        is_gray;
    } t_hsv;

    t_hsv        expected_hsv_q[$];
    logic [15:0] gray_threshold;

    // Converts one pixel to HSV under the given gray threshold.
    function automatic t_hsv convert_pixel(input logic [15:0] red, input logic [15:0] green,
                                           input logic [15:0] blue,
                                           input logic [15:0] threshold);
        logic [15:0]         top_level;
        logic [15:0]         low_level;
        logic [15:0]         spread;
        longint              diff;
        longint              hue;
        rgbhsv_pkg::t_sector sector;
        t_hsv                res;
        top_level = (red > green) ? red : green;
        top_level = (top_level > blue) ? top_level : blue;
        low_level = (red < green) ? red : green;
        low_level = (low_level < blue) ? low_level : blue;
        spread    = top_level - low_level;
        res            = '0;
        res.brightness = top_level;
        res.is_gray    = (spread == 16'd0) || (spread < threshold);
        if (!res.is_gray) begin
            res.saturation = 16'((FULL_SCALE * longint'(spread)) / longint'(top_level));
            // Ties go to red first, then to green.
            if (red >= top_level) begin
                sector = rgbhsv_pkg::SECT_RED;
                diff   = longint'(green) - longint'(blue);
            end else if (green >= top_level) begin
                sector = rgbhsv_pkg::SECT_GREEN;
                diff   = longint'(blue) - longint'(red);
            end else begin
                sector = rgbhsv_pkg::SECT_BLUE;
                diff   = longint'(red) - longint'(green);
            end
            hue = longint'(sector) * longint'(rgbhsv_pkg::HUE_SECTOR)
                + (HALF_SECTOR * diff) / longint'(spread);
            if (hue < 0) begin
                hue = hue + longint'(rgbhsv_pkg::HUE_FULL_TURN);
            end
            res.hue_x64 = 15'(hue);
        end
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            o_mismatch_count = o_mismatch_count + 1;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
        gray_threshold   = rgbhsv_pkg::CFG_THR_RESET;
    end

    // Results are checked before new pixels are predicted; the threshold a
    // pixel sees is the one in force at its acceptance.
    always @(posedge i_clk) begin
        t_hsv want;
        if (!i_rst_n) begin
            gray_threshold = rgbhsv_pkg::CFG_THR_RESET;
        end else begin
            if (i_hsv_valid && !i_hsv_stall) begin
                if (expected_hsv_q.size() == 0) begin
                    o_mismatch_count = o_mismatch_count + 1;
                    $display("%0t ns: unexpected result, expected none, %s %0d %0d %0d %0d",
                             $time, "got hue, sat, val, gray", i_hue_x64, i_saturation,
                             i_brightness, i_is_gray);
                end else begin
                    want = expected_hsv_q.pop_front();
                    check_field("hue", 32'(want.hue_x64), 32'(i_hue_x64));
                    check_field("saturation", 32'(want.saturation), 32'(i_saturation));
                    check_field("brightness", 32'(want.brightness), 32'(i_brightness));
                    check_field("gray flag", 32'(want.is_gray), 32'(i_is_gray));
                end
            end
            if (i_pix_valid && !i_pix_stall) begin
                expected_hsv_q.push_back(convert_pixel(i_red_level, i_green_level,
                                                       i_blue_level, gray_threshold));
            end
            if (i_cfg_we) begin
                gray_threshold = i_cfg_wdata;
            end
        end
        o_pending <= expected_hsv_q.size();
    end

endmodule

### tb/sv/rgb_to_hsv_pixel_test.sv
`timescale 1ns / 100ps
// ============================================================================
// RGB to HSV pixel converter test
// Drives directed and random pixels through the converter under several gray
// thresholds, with random gaps on the pixel side and random stalls on the
// result side; a separate check module predicts and compares every result.
// ============================================================================
module rgb_to_hsv_pixel_test;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        pix_valid   = 1'b0;
    logic        pix_stall;
    logic [15:0] red_level   = '0;
    logic [15:0] green_level = '0;
    logic [15:0] blue_level  = '0;
    logic        hsv_valid;
    logic        hsv_stall   = 1'b0;
    logic [14:0] hue_x64;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic        is_gray;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = '0;

    int          mismatch_count;
    int          pending;
    logic        idle_on       = 1'b1;
    logic [15:0] cur_threshold = rgbhsv_pkg::CFG_THR_RESET;

    // 20 ns clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rgb_to_hsv_pixel #(
        .COLOR_BITS(16)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix_valid  (pix_valid),
        .o_pix_stall  (pix_stall),
        .i_red_level  (red_level),
        .i_green_level(green_level),
        .i_blue_level (blue_level),
        .o_hsv_valid  (hsv_valid),
        .i_hsv_stall  (hsv_stall),
        .o_hue_x64    (hue_x64),
        .o_saturation (saturation),
        .o_brightness (brightness),
        .o_is_gray    (is_gray),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata)
    );

    rgb_to_hsv_pixel_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_pix_valid     (pix_valid),
        .i_pix_stall     (pix_stall),
        .i_red_level     (red_level),
        .i_green_level   (green_level),
        .i_blue_level    (blue_level),
        .i_hsv_valid     (hsv_valid),
        .i_hsv_stall     (hsv_stall),
        .i_hue_x64       (hue_x64),
        .i_saturation    (saturation),
        .i_brightness    (brightness),
        .i_is_gray       (is_gray),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending)
    );

    // Random stalls on the result side.
    always @(negedge clk) begin
        hsv_stall <= idle_on && ($urandom_range(0, 99) < 18);
    end

    // Offers one pixel, after random gaps, and holds it until accepted.
    task automatic send_pixel(input logic [15:0] red, input logic [15:0] green,
                              input logic [15:0] blue);
        @(negedge clk);
        while (idle_on && ($urandom_range(0, 99) < 18)) begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid   <= 1'b1;
        red_level   <= red;
        green_level <= green;
        blue_level  <= blue;
        do @(posedge clk); while (pix_stall);
    endtask

    // Lets the converter drain, then writes a new gray threshold.
    task automatic write_threshold(input logic [15:0] value);
        @(negedge clk);
        pix_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we        <= 1'b0;
        cur_threshold = value;
    endtask

    // Random pixels: fully random channels, a chosen spread between the smallest
    // and largest channel, often right at the gray threshold, or ties and extremes.
    task automatic send_random_pixels(input int count);
        logic [15:0] low_v;
        logic [15:0] span;
        logic [15:0] mid_v;
        logic [15:0] high_v;
        logic [15:0] chan [3];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 35) begin
                for (int c = 0; c < 3; c++) chan[c] = 16'($urandom);
            end else if ($urandom_range(0, 99) < 75) begin
                case ($urandom_range(0, 5))
                    0:       span = (cur_threshold == 16'h0000) ? 16'h0000
                                                                : cur_threshold - 16'd1;
                    1:       span = cur_threshold;
                    2:       span = (cur_threshold == 16'hFFFF) ? 16'hFFFF
                                                                : cur_threshold + 16'd1;
                    3:       span = 16'($urandom_range(0, 512));
                    4:       span = 16'($urandom_range(0, 65535));
                    default: span = 16'hFFFF;
                endcase
                low_v  = 16'($urandom_range(0, 32'd65535 - 32'(span)));
                high_v = low_v + span;
                case ($urandom_range(0, 2))
                    0:       mid_v = low_v;
                    1:       mid_v = high_v;
                    default: mid_v = 16'($urandom_range(32'(low_v), 32'(high_v)));
                endcase
                case ($urandom_range(0, 5))
                    0:       begin chan[0] = low_v;  chan[1] = mid_v;  chan[2] = high_v; end
                    1:       begin chan[0] = low_v;  chan[1] = high_v; chan[2] = mid_v;  end
                    2:       begin chan[0] = mid_v;  chan[1] = low_v;  chan[2] = high_v; end
                    3:       begin chan[0] = mid_v;  chan[1] = high_v; chan[2] = low_v;  end
                    4:       begin chan[0] = high_v; chan[1] = low_v;  chan[2] = mid_v;  end
                    default: begin chan[0] = high_v; chan[1] = mid_v;  chan[2] = low_v;  end
                endcase
            end else begin
                for (int c = 0; c < 3; c++) begin
                    case ($urandom_range(0, 2))
                        0:       chan[c] = 16'h0000;
                        1:       chan[c] = 16'hFFFF;
                        default: chan[c] = 16'($urandom);
                    endcase
                end
            end
            send_pixel(chan[0], chan[1], chan[2]);
        end
    endtask

    // Ends the run if the converter hangs.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset threshold: primaries, ties, wrap-around and one-step spreads.
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0001, 16'h0001, 16'h0001);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001);
        send_pixel(16'h0001, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0001, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h0001);
        send_pixel(16'hFFFE, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h7FFF, 16'h8000);
        send_pixel(16'h1234, 16'hABCD, 16'h5678);
        send_pixel(16'hABCD, 16'h1234, 16'h5678);
        send_pixel(16'h5678, 16'h1234, 16'hABCD);
        send_pixel(16'hAAAA, 16'h5555, 16'h0000);
        send_pixel(16'h5555, 16'hAAAA, 16'hFFFF);
        send_random_pixels(400);

        // Zero threshold: a flat pixel is still gray.
        write_threshold(16'h0000);
        send_pixel(16'h0007, 16'h0007, 16'h0007);
        send_pixel(16'h0007, 16'h0008, 16'h0007);
        send_random_pixels(300);

        // Largest threshold: only a full-scale spread has a hue.
        write_threshold(16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'hFFFE, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        send_random_pixels(250);

        // Random threshold at full rate on both sides.
        write_threshold(16'($urandom_range(2, 65534)));
        idle_on = 1'b0;
        send_random_pixels(400);
        idle_on = 1'b1;

        // Small threshold with spreads on either side of it.
        write_threshold(16'd256);
        send_pixel(16'h0100, 16'h0000, 16'h0000);
        send_pixel(16'h00FF, 16'h0000, 16'h0000);
        send_pixel(16'h0200, 16'h0300, 16'h0201);
        send_random_pixels(350);

        @(negedge clk);
        pix_valid <= 1'b0;
        wait (pending == 0);
        repeat (25) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
